// ----- hdl/plst_pkg.sv -----
`timescale 1ns / 1ps

package plst_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(2);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PUT,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic              op;
    logic signed [31:0] value;
    logic [6:0]        position;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic              element_valid;
    logic signed [31:0] element_value;
    logic [5:0]        slot;
    logic [6:0]        entry_count;
    logic [6:0]        logical_capacity;
    logic              last;
  } rsp_t;

  // One result slot handed from the sequencer to the output queue.
  typedef struct packed {
    logic valid;
    logic use_mem;
    rsp_t res;
  } issue_t;

endpackage

// ----- hdl/plst_ram.sv -----
`timescale 1ns / 1ps

module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/plst_ctrl.sv -----
`timescale 1ns / 1ps

module plst_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  plst_pkg::cmd_t                cmd,
  input  logic                          room,
  output plst_pkg::issue_t              iss,
  output logic                          ram_re,
  output logic [plst_pkg::ADDR_W-1:0]   ram_raddr,
  output logic                          ram_we,
  output logic [plst_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [plst_pkg::DATA_W-1:0]   ram_wdata,
  input  logic [plst_pkg::DATA_W-1:0]   ram_rdata
);
  import plst_pkg::*;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    cap;
  logic [ADDR_W-1:0]   ptr;
  logic [CNT_W-1:0]    left;
  logic                is_del;
  logic [ADDR_W-1:0]   pos_r;
  logic [DATA_W-1:0]   val_r;
  logic                wpend;
  logic [ADDR_W-1:0]   wptr;

  logic                accept;
  logic                reject;
  logic                ptr_last;
  logic [CNT_W+1:0]    cnt4;
  logic [CNT_W+1:0]    cap3;
  logic [CNT_W:0]      cap2;
  logic [CNT_W-1:0]    cap_half;
  logic [CNT_W-1:0]    cap_grow;
  logic [CNT_W-1:0]    cap_shrink;

  assign cmd_stall = !((state == ST_IDLE) && room);
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    if (cmd.op == OP_INSERT) begin
      reject = (cmd.position > count) || (count == CNT_W'(DEPTH));
    end else begin
      reject = (count == '0) || (cmd.position >= count);
    end
  end

  assign ptr_last = ({1'b0, ptr} == count - CNT_W'(1));

  // capacity policy: grow at three quarters full, shrink at one quarter
  assign cnt4     = {count, 2'b00};
  assign cap3     = {2'b00, cap} + {1'b0, cap, 1'b0};
  assign cap2     = {cap, 1'b0};
  assign cap_half = cap >> 1;

  always_comb begin
    cap_grow = cap;
    if (cnt4 >= cap3) begin
      cap_grow = (cap2 > (CNT_W+1)'(DEPTH)) ? CNT_W'(DEPTH) : cap2[CNT_W-1:0];
    end
    cap_shrink = cap;
    if (cnt4 <= {2'b00, cap}) begin
      cap_shrink = (cap_half == '0) ? CNT_W'(1) : cap_half;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !reject) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (left == '0 && !wpend) begin
          state_next = is_del ? ST_DUMP : ST_PUT;
        end
      end
      ST_PUT: begin
        state_next = ST_DUMP;
      end
      ST_DUMP: begin
        if (room && (count == '0 || ptr_last)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    iss       = '0;
    iss.res.entry_count      = count;
    iss.res.logical_capacity = cap;
    ram_re    = 1'b0;
    ram_raddr = ptr;
    ram_we    = wpend;
    ram_waddr = wptr;
    ram_wdata = ram_rdata;
    unique case (state)
      ST_IDLE: begin
        if (accept && reject) begin
          iss.valid      = 1'b1;
          iss.res.status = STATUS_REJECT;
          iss.res.last   = 1'b1;
        end
      end
      ST_SHIFT: begin
        ram_re = (left != '0);
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
      end
      ST_DUMP: begin
        if (room) begin
          iss.valid      = 1'b1;
          iss.res.status = STATUS_OK;
          if (count == '0) begin
            iss.res.last = 1'b1;
          end else begin
            iss.use_mem           = 1'b1;
            ram_re                = 1'b1;
            iss.res.element_valid = 1'b1;
            iss.res.slot          = ptr;
            iss.res.last          = ptr_last;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      cap   <= CAP_RESET;
      wpend <= 1'b0;
    end else begin
      state <= state_next;
      wpend <= (state == ST_SHIFT) && (left != '0);
      if (state == ST_IDLE && accept && !reject) begin
        if (cmd.op == OP_INSERT) begin
          count <= count + CNT_W'(1);
          cap   <= cap_grow;
        end else begin
          count <= count - CNT_W'(1);
          cap   <= cap_shrink;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        is_del <= (cmd.op == OP_DELETE);
        pos_r  <= cmd.position[ADDR_W-1:0];
        val_r  <= cmd.value;
        if (cmd.op == OP_INSERT) begin
          // walk down from the old tail, copying each entry one slot up
          ptr  <= ADDR_W'(count - CNT_W'(1));
          left <= count - cmd.position;
        end else begin
          // walk up from the slot after the hole, copying one slot down
          ptr  <= ADDR_W'(cmd.position + CNT_W'(1));
          left <= count - CNT_W'(1) - cmd.position;
        end
      end
      ST_SHIFT: begin
        if (left != '0) begin
          ptr  <= is_del ? ptr + ADDR_W'(1) : ptr - ADDR_W'(1);
          left <= left - CNT_W'(1);
          wptr <= is_del ? ptr - ADDR_W'(1) : ptr + ADDR_W'(1);
        end else if (!wpend) begin
          ptr <= '0;
        end
      end
      ST_PUT: begin
      end
      ST_DUMP: begin
        if (room && count != '0) begin
          ptr <= ptr + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/plst_outq.sv -----
`timescale 1ns / 1ps

module plst_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  plst_pkg::issue_t            iss,
  input  logic [plst_pkg::DATA_W-1:0] ram_rdata,
  output logic                        room,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output plst_pkg::rsp_t              rsp
);
  import plst_pkg::*;

  issue_t     pend;
  rsp_t       q [2];
  logic [1:0] occ;
  logic [1:0] occ_rem;
  logic [1:0] occ_next;
  logic       pop;
  logic       push;
  rsp_t       push_data;

  assign pop      = (occ != 2'd0) && !rsp_stall;
  assign push     = pend.valid;
  assign occ_rem  = occ - {1'b0, pop};
  assign occ_next = occ_rem + {1'b0, push};
  // a read issued now lands next cycle, so keep one slot free for it
  assign room     = (occ_next < 2'd2);

  always_comb begin
    push_data = pend.res;
    push_data.element_value = pend.use_mem ? ram_rdata : '0;
  end

  assign rsp_valid = (occ != 2'd0);
  assign rsp       = q[0];

  always_ff @(posedge clk) begin
    pend.use_mem <= iss.use_mem;
    pend.res     <= iss.res;
    if (rst) begin
      occ        <= 2'd0;
      pend.valid <= 1'b0;
    end else begin
      occ        <= occ_next;
      pend.valid <= iss.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push && occ_rem == 2'd0) begin
      q[0] <= push_data;
    end else if (pop) begin
      q[0] <= q[1];
    end
    if (push && occ_rem == 2'd1) begin
      q[1] <= push_data;
    end
  end

endmodule

// ----- hdl/positional_insert_delete_list.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake              | Payload
// cmd     | in  | cmd_valid / cmd_stall  | plst_pkg::cmd_t (op, value, position)
// rsp     | out | rsp_valid / rsp_stall  | plst_pkg::rsp_t (one list element or status)
//
// An accepted insert at position p with n entries copies entries p to n - 1 one slot up,
// tail first, then writes the value at p; a delete moves the entries after p one slot down.
// The list then streams out at one result per cycle while rsp is not stalled, each result
// passing through the pend register and the output queue to rsp; a rejected transaction's
// status result takes the same path. Reset is synchronous; the entry RAM is not cleared.
// A stalled rsp only pauses the readout; the 2-deep output queue holds in-flight data.

module positional_insert_delete_list (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  plst_pkg::cmd_t   cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output plst_pkg::rsp_t   rsp
);
  import plst_pkg::*;

  issue_t              iss;
  logic                room;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  plst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .room      (room),
    .iss       (iss),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  plst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plst_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .iss       (iss),
    .ram_rdata (ram_rdata),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- hdl/plst_chk.sv -----
`timescale 1ns / 1ps

module plst_chk (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input plst_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input plst_pkg::rsp_t rsp
);
  import plst_pkg::*;

  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("cmd changed while stalled");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_REJECT |-> rsp.last && !rsp.element_valid)
    else $error("reject result is not a single status result");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.element_valid |->
      ({1'b0, rsp.slot} < rsp.entry_count) && (rsp.entry_count <= rsp.logical_capacity))
    else $error("element slot outside list or count above capacity");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.element_valid && rsp.last |->
      {1'b0, rsp.slot} == rsp.entry_count - 7'd1)
    else $error("last element is not the list tail");

endmodule

bind positional_insert_delete_list plst_chk u_plst_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- bench/positional_insert_delete_list_test.sv -----
`timescale 1ns / 1ps

module positional_insert_delete_list_test;
  import plst_pkg::*;

  typedef struct {
    cmd_t        c;
    int unsigned gap;
  } queued_cmd_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} traffic_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  positional_insert_delete_list u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // shadow of the list contents, updated as commands are accepted
  logic signed [31:0] list_vals [DEPTH];
  logic [6:0]         list_count = '0;
  logic [6:0]         list_cap = CAP_RESET;
  rsp_t               listing_q [$];

  queued_cmd_t pending_cmds [$];
  queued_cmd_t next_cmd;
  rsp_t        want;
  int unsigned gap_left = 0;
  int          rsp_wait = 0;
  bit          hold_rsp = 1'b0;
  bit          rsp_no_wait = 1'b0;
  bit          tx_no_gap = 1'b0;
  logic        cmd_accepted = 1'b0;
  logic        load_cmd;
  int          plan_count = 0;
  int          cmds_taken = 0;
  int          error_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one accepted command and queue the listing it should produce.
  task automatic update_list_model(input cmd_t c);
    rsp_t r;
    int   i;
    int   grown;
    r = '0;
    r.last = 1'b1;
    if (c.op == OP_INSERT) begin
      if (c.position > list_count || int'(list_count) >= DEPTH) begin
        r.status = STATUS_REJECT;
        r.entry_count = list_count;
        r.logical_capacity = list_cap;
        listing_q.push_back(r);
        return;
      end
      if (int'(list_count) * 4 >= int'(list_cap) * 3) begin
        grown = int'(list_cap) * 2;
        list_cap = 7'((grown > DEPTH) ? DEPTH : grown);
      end
      for (i = int'(list_count); i > int'(c.position); i--)
        list_vals[i] = list_vals[i-1];
      list_vals[c.position[5:0]] = c.value;
      list_count++;
    end else begin
      if (list_count == 0 || c.position >= list_count) begin
        r.status = STATUS_REJECT;
        r.entry_count = list_count;
        r.logical_capacity = list_cap;
        listing_q.push_back(r);
        return;
      end
      if (int'(list_count) * 4 <= int'(list_cap))
        list_cap = (list_cap > 1) ? (list_cap >> 1) : 7'd1;
      for (i = int'(c.position); i + 1 < int'(list_count); i++)
        list_vals[i] = list_vals[i+1];
      list_count--;
    end
    if (list_count == 0) begin
      r.status = STATUS_OK;
      r.logical_capacity = list_cap;
      listing_q.push_back(r);
      return;
    end
    for (i = 0; i < int'(list_count); i++) begin
      r.status = STATUS_OK;
      r.element_valid = 1'b1;
      r.element_value = list_vals[i];
      r.slot = 6'(i);
      r.entry_count = list_count;
      r.logical_capacity = list_cap;
      r.last = (i + 1 == int'(list_count));
      listing_q.push_back(r);
    end
  endtask

  task automatic check_result(input rsp_t exp_r, input rsp_t got);
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      error_count++;
    end
    if (got.element_valid !== exp_r.element_valid) begin
      $error("element_valid: expected %0d, got %0d", exp_r.element_valid, got.element_valid);
      error_count++;
    end
    if (got.element_value !== exp_r.element_value) begin
      $error("element_value: expected %0d, got %0d", exp_r.element_value, got.element_value);
      error_count++;
    end
    if (got.slot !== exp_r.slot) begin
      $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
      error_count++;
    end
    if (got.entry_count !== exp_r.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp_r.entry_count, got.entry_count);
      error_count++;
    end
    if (got.logical_capacity !== exp_r.logical_capacity) begin
      $error("logical_capacity: expected %0d, got %0d",
             exp_r.logical_capacity, got.logical_capacity);
      error_count++;
    end
    if (got.last !== exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, got.last);
      error_count++;
    end
  endtask

  // Queue a command; plan_count tracks the list size so the generator can aim positions.
  task automatic queue_cmd(input logic op, input logic signed [31:0] v, input int pos);
    queued_cmd_t q;
    q.c.op = op;
    q.c.value = v;
    q.c.position = 7'(pos);
    q.gap = tx_no_gap ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 19) == 0)
      tx_no_gap = !tx_no_gap;
    pending_cmds.push_back(q);
    if (op == OP_INSERT) begin
      if (pos <= plan_count && plan_count < DEPTH)
        plan_count++;
    end else if (pos < plan_count) begin
      plan_count--;
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Driver: transactions change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_accepted) begin
      load_cmd = 1'b0;
      if (gap_left > 0)
        gap_left--;
      else if (pending_cmds.size() > 0)
        load_cmd = 1'b1;
      if (load_cmd) begin
        next_cmd = pending_cmds.pop_front();
        cmd <= next_cmd.c;
        gap_left = next_cmd.gap;
      end
      cmd_valid <= load_cmd;
    end
  end

  always @(negedge clk) begin
    if (rst || (!hold_rsp && rsp_wait == 0)) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= 1'b1;
      if (!hold_rsp)
        rsp_wait--;
    end
  end

  // Monitor: commands go through the model before results are checked.
  always @(posedge clk) begin
    if (rst) begin
      cmd_accepted <= 1'b0;
    end else begin
      cmd_accepted <= cmd_valid && !cmd_stall;
      if (cmd_valid && !cmd_stall) begin
        update_list_model(cmd);
        cmds_taken++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (listing_q.size() == 0) begin
          $error("result with nothing expected: status %0d value %0d slot %0d",
                 rsp.status, rsp.element_value, rsp.slot);
          error_count++;
        end else begin
          want = listing_q.pop_front();
          check_result(want, rsp);
        end
        rsp_wait = rsp_no_wait ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 49) == 0)
          rsp_no_wait = !rsp_no_wait;
      end
    end
  end

  // Long receiver hold-off so the block backs up into the command channel.
  initial begin
    while (cmds_taken < 60) @(posedge clk);
    hold_rsp = 1'b1;
    repeat (300) @(posedge clk);
    hold_rsp = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("positional_insert_delete_list regression: fail");
    $finish;
  end

  initial begin
    traffic_phase_t phase;
    int             n;
    int             pos;
    int             at_full;
    logic           op;

    // directed: empty rejects, growth, bounds, shrink, empty result
    queue_cmd(OP_DELETE, 32'sd5, 0);
    queue_cmd(OP_INSERT, 32'sd7, 1);
    queue_cmd(OP_INSERT, 32'sh7fff_ffff, 0);
    queue_cmd(OP_INSERT, 32'sh8000_0000, 0);
    queue_cmd(OP_INSERT, -32'sd1, 2);
    queue_cmd(OP_INSERT, 32'sd0, 1);
    queue_cmd(OP_INSERT, 32'sd3, 64);
    queue_cmd(OP_DELETE, 32'sd0, 4);
    queue_cmd(OP_DELETE, 32'sd0, 64);
    queue_cmd(OP_DELETE, 32'sd0, 3);
    queue_cmd(OP_DELETE, 32'sd0, 0);
    queue_cmd(OP_DELETE, 32'sd0, 1);
    queue_cmd(OP_DELETE, 32'sd0, 0);
    queue_cmd(OP_DELETE, 32'sd0, 0);
    queue_cmd(OP_INSERT, 32'sh5555_5555, 0);
    queue_cmd(OP_INSERT, 32'shAAAA_AAAA, 1);
    queue_cmd(OP_INSERT, 32'sh0F0F_0F0F, 1);
    queue_cmd(OP_DELETE, 32'sd0, 1);
    queue_cmd(OP_DELETE, 32'sd0, 1);
    queue_cmd(OP_DELETE, 32'sd0, 0);

    // random: fill to full, drain to empty, then mixed traffic
    phase = PH_FILL;
    at_full = 0;
    for (n = 0; n < 250; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        op = 1'($urandom_range(0, 1));
        pos = $urandom_range(0, 64);
      end else begin
        case (phase)
          PH_FILL:  op = ($urandom_range(0, 99) < 90) ? OP_INSERT : OP_DELETE;
          PH_DRAIN: op = ($urandom_range(0, 99) < 10) ? OP_INSERT : OP_DELETE;
          default:  op = 1'($urandom_range(0, 1));
        endcase
        if (op == OP_INSERT) begin
          case ($urandom_range(0, 5))
            0: pos = 0;
            1: pos = plan_count;
            default: pos = $urandom_range(0, plan_count);
          endcase
        end else begin
          pos = (plan_count == 0) ? 0 : $urandom_range(0, plan_count - 1);
        end
      end
      if (plan_count == DEPTH)
        at_full++;
      queue_cmd(op, pick_value(), pos);
      if (phase == PH_FILL && at_full >= 3)
        phase = PH_DRAIN;
      else if (phase == PH_DRAIN && plan_count == 0)
        phase = PH_MIX;
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || cmd_valid) @(posedge clk);
    while (listing_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0)
      $display("positional_insert_delete_list regression: pass");
    else
      $display("positional_insert_delete_list regression: fail");
    $finish;
  end

endmodule
